@@ sv/cmfp_pkg.sv @@
// Shared types and codes for the cube map face projection block.
`default_nettype none
package cmfp_pkg;

  // Face codes: twice the major axis, plus one for a negative major component
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  // Major axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Side information that rides along the divider chain with each word
  typedef struct packed {
    logic [2:0] face;
    logic       zero_dir;
    logic       sat_u;
    logic       sat_v;
  } tag_t;

endpackage
`default_nettype wire

@@ sv/cmfp_front.sv @@
// Front stage: major axis pick, face code and dividend setup for both coordinates.
`default_nettype none
module cmfp_front #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [COORD_BITS-1:0] dir_x,
  input  wire  signed [COORD_BITS-1:0] dir_y,
  input  wire  signed [COORD_BITS-1:0] dir_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output cmfp_pkg::tag_t               out_tag,
  output logic [COORD_BITS-1:0]        out_m,
  output logic [COORD_BITS:0]          out_ru,
  output logic [COORD_BITS:0]          out_rv
);

  localparam int CB = COORD_BITS;

  logic [CB-1:0]   ax, ay, az;
  logic [1:0]      axis;
  logic            neg;
  logic [2:0]      face_c;
  logic [CB-1:0]   m_c;
  logic [CB+1:0]   cx, cy, cz;
  logic [CB+1:0]   su, sv;
  logic [CB+1:0]   tu_s, tv_s;
  logic [CB:0]     tu, tv, two_m;
  logic            sat_u_c, sat_v_c;

  // Magnitudes; the most negative value maps to 2^(CB-1) without wrap
  assign ax = dir_x[CB-1] ? (~dir_x + {{(CB-1){1'b0}}, 1'b1}) : dir_x;
  assign ay = dir_y[CB-1] ? (~dir_y + {{(CB-1){1'b0}}, 1'b1}) : dir_y;
  assign az = dir_z[CB-1] ? (~dir_z + {{(CB-1){1'b0}}, 1'b1}) : dir_z;

  // Major axis: Z wins ties over Y, Y over X
  always_comb begin
    if (az >= ax && az >= ay) begin
      axis = cmfp_pkg::AXIS_Z;
      neg  = dir_z[CB-1];
      m_c  = az;
    end else if (ay >= ax && ay >= az) begin
      axis = cmfp_pkg::AXIS_Y;
      neg  = dir_y[CB-1];
      m_c  = ay;
    end else begin
      axis = cmfp_pkg::AXIS_X;
      neg  = dir_x[CB-1];
      m_c  = ax;
    end
  end

  assign face_c = {axis, neg};

  // Sign-extended components, two guard bits
  assign cx = {{2{dir_x[CB-1]}}, dir_x};
  assign cy = {{2{dir_y[CB-1]}}, dir_y};
  assign cz = {{2{dir_z[CB-1]}}, dir_z};

  // Face table: signed minor component feeding u and v
  always_comb begin
    case (face_c)
      cmfp_pkg::FACE_PX: begin su = -cz; sv = -cy; end
      cmfp_pkg::FACE_NX: begin su =  cz; sv = -cy; end
      cmfp_pkg::FACE_PY: begin su =  cx; sv =  cz; end
      cmfp_pkg::FACE_NY: begin su =  cx; sv = -cz; end
      cmfp_pkg::FACE_PZ: begin su =  cx; sv = -cy; end
      cmfp_pkg::FACE_NZ: begin su = -cx; sv = -cy; end
      default:           begin su = '0;  sv = '0;  end
    endcase
  end

  // Dividend t = m + minor, in [0, 2m]
  assign tu_s  = {2'b00, m_c} + su;
  assign tv_s  = {2'b00, m_c} + sv;
  assign tu    = tu_s[CB+1] ? '0 : tu_s[CB:0];
  assign tv    = tv_s[CB+1] ? '0 : tv_s[CB:0];
  assign two_m = {m_c, 1'b0};

  // t == 2m means exactly 1.0, which saturates
  assign sat_u_c = (tu == two_m);
  assign sat_v_c = (tv == two_m);

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_tag.face     <= face_c;
      out_tag.zero_dir <= (m_c == '0);
      out_tag.sat_u    <= sat_u_c;
      out_tag.sat_v    <= sat_v_c;
      out_m            <= m_c;
      out_ru           <= sat_u_c ? '0 : tu;
      out_rv           <= sat_v_c ? '0 : tv;
    end
  end

endmodule
`default_nettype wire

@@ sv/cmfp_cell.sv @@
// Divider cell: one restoring quotient bit for u and for v per stage.
`default_nettype none
module cmfp_cell #(
  parameter int COORD_BITS = 16,
  parameter int QUOT_BITS  = 17
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  cmfp_pkg::tag_t         in_tag,
  input  wire  [COORD_BITS-1:0]  in_m,
  input  wire  [COORD_BITS:0]    in_ru,
  input  wire  [COORD_BITS:0]    in_rv,
  input  wire  [QUOT_BITS-1:0]   in_qu,
  input  wire  [QUOT_BITS-1:0]   in_qv,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cmfp_pkg::tag_t         out_tag,
  output logic [COORD_BITS-1:0]  out_m,
  output logic [COORD_BITS:0]    out_ru,
  output logic [COORD_BITS:0]    out_rv,
  output logic [QUOT_BITS-1:0]   out_qu,
  output logic [QUOT_BITS-1:0]   out_qv
);

  localparam int CB = COORD_BITS;

  logic [CB:0] m_ext;
  logic        bu, bv;
  logic [CB:0] du, dv;

  // Remainder stays below 2m, so one compare and subtract per bit
  assign m_ext = {1'b0, in_m};
  assign bu    = (in_ru >= m_ext);
  assign bv    = (in_rv >= m_ext);
  assign du    = bu ? (in_ru - m_ext) : in_ru;
  assign dv    = bv ? (in_rv - m_ext) : in_rv;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_tag <= in_tag;
      out_m   <= in_m;
      out_ru  <= {du[CB-1:0], 1'b0};
      out_rv  <= {dv[CB-1:0], 1'b0};
      out_qu  <= {in_qu[QUOT_BITS-2:0], bu};
      out_qv  <= {in_qv[QUOT_BITS-2:0], bv};
    end
  end

  // Partial remainders keep the restoring invariant
  a_ru_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_tag.zero_dir |-> out_ru < {out_m, 1'b0})
    else $error("u remainder out of range");

  a_rv_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_tag.zero_dir |-> out_rv < {out_m, 1'b0})
    else $error("v remainder out of range");

endmodule
`default_nettype wire

@@ sv/cube_map_face_projection_unit.sv @@
// Top level: cube map face selection with a chain of divider cells for u and v.
//
// Usage: a direction word (dir_x, dir_y, dir_z, signed Q1.15) enters on the
// dir_valid/dir_ready channel; the result word (face, coord_u, coord_v,
// zero_direction) leaves on res_valid/res_ready. One result per direction,
// in order.
// Throughput: one word per cycle while res_ready is held high. Stages: one
// front stage for axis pick and dividend setup, then UV_BITS + 1 divider
// cells, each retiring one quotient bit of u and of v.
// Rounding and saturation sit after the last cell.
// Each stage holds its word until the next stage can take it, so bubbles
// close up while the receiver stalls; dir_ready drops only when every stage
// is full and the last word waits on res_ready.
// Reset clears all stage valid bits; no results are pending afterwards.
// An all-zero direction gives face 4, both coordinates at half scale and
// zero_direction set.
`default_nettype none
module cube_map_face_projection_unit #(
  parameter int COORD_BITS = 16,
  parameter int UV_BITS    = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          dir_valid,
  output logic                         dir_ready,
  input  wire  signed [COORD_BITS-1:0] dir_x,
  input  wire  signed [COORD_BITS-1:0] dir_y,
  input  wire  signed [COORD_BITS-1:0] dir_z,
  output logic                         res_valid,
  input  wire                          res_ready,
  output logic [2:0]                   face,
  output logic [UV_BITS-1:0]           coord_u,
  output logic [UV_BITS-1:0]           coord_v,
  output logic                         zero_direction
);

  localparam int CB     = COORD_BITS;
  localparam int QB     = UV_BITS + 1;
  localparam int NCELLS = UV_BITS + 1;

  logic                 c_valid [NCELLS+1];
  logic                 c_ready [NCELLS+1];
  cmfp_pkg::tag_t       c_tag   [NCELLS+1];
  logic [CB-1:0]        c_m     [NCELLS+1];
  logic [CB:0]          c_ru    [NCELLS+1];
  logic [CB:0]          c_rv    [NCELLS+1];
  logic [QB-1:0]        c_qu    [NCELLS+1];
  logic [QB-1:0]        c_qv    [NCELLS+1];

  // Front stage feeds link zero of the chain
  cmfp_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dir_valid),
    .in_ready  (dir_ready),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_tag   (c_tag[0]),
    .out_m     (c_m[0]),
    .out_ru    (c_ru[0]),
    .out_rv    (c_rv[0])
  );

  assign c_qu[0] = '0;
  assign c_qv[0] = '0;

  // Divider chain: quotient bits from weight 2^UV_BITS down to 2^0
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    cmfp_cell #(
      .COORD_BITS (COORD_BITS),
      .QUOT_BITS  (QB)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_tag    (c_tag[i]),
      .in_m      (c_m[i]),
      .in_ru     (c_ru[i]),
      .in_rv     (c_rv[i]),
      .in_qu     (c_qu[i]),
      .in_qv     (c_qv[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_tag   (c_tag[i+1]),
      .out_m     (c_m[i+1]),
      .out_ru    (c_ru[i+1]),
      .out_rv    (c_rv[i+1]),
      .out_qu    (c_qu[i+1]),
      .out_qv    (c_qv[i+1])
    );
  end

  assign res_valid           = c_valid[NCELLS];
  assign c_ready[NCELLS]     = res_ready;

  // Round half up, saturate at all ones, force half scale for zero direction
  logic [QB-1:0]      qu_f, qv_f;
  logic [QB:0]        ru_sum, rv_sum;
  logic               sat_u, sat_v;
  logic [UV_BITS-1:0] half;
  cmfp_pkg::tag_t     tag_f;

  assign tag_f  = c_tag[NCELLS];
  assign qu_f   = c_qu[NCELLS];
  assign qv_f   = c_qv[NCELLS];
  assign ru_sum = {1'b0, qu_f} + {{QB{1'b0}}, 1'b1};
  assign rv_sum = {1'b0, qv_f} + {{QB{1'b0}}, 1'b1};
  assign sat_u  = tag_f.sat_u || (&qu_f);
  assign sat_v  = tag_f.sat_v || (&qv_f);
  assign half   = {1'b1, {(UV_BITS-1){1'b0}}};

  always_comb begin
    face           = tag_f.face;
    zero_direction = tag_f.zero_dir;
    if (tag_f.zero_dir) begin
      coord_u = half;
      coord_v = half;
    end else begin
      coord_u = sat_u ? '1 : ru_sum[UV_BITS:1];
      coord_v = sat_v ? '1 : rv_sum[UV_BITS:1];
    end
  end

  // Input stalls only when the whole chain is full behind a waiting result
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !dir_ready |-> res_valid && !res_ready)
    else $error("input stalled while chain has room");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> face <= cmfp_pkg::FACE_NZ)
    else $error("face code out of range");

  a_zero_face: assert property (@(posedge clk) disable iff (rst)
    res_valid && zero_direction |-> face == cmfp_pkg::FACE_PZ)
    else $error("zero direction not mapped to +Z face");

endmodule
`default_nettype wire
